[rtl/csvtok_pkg.sv]
// Shared types and constants for the CSV record tokenizer.
package csvtok_pkg;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  localparam logic [15:0] COL_MAX = 16'hFFFF;

  localparam int unsigned NUM_SLOTS  = 4;
  localparam int unsigned SLOT_BEGIN = 0;
  localparam int unsigned SLOT_VALUE = 1;
  localparam int unsigned SLOT_END   = 2;
  localparam int unsigned SLOT_FIN   = 3;

  typedef enum logic [2:0] {
    EV_ROW_BEGIN  = 3'd0,
    EV_VALUE      = 3'd1,
    EV_ROW_END    = 3'd2,
    EV_FINISHED   = 3'd3,
    EV_INCOMPLETE = 3'd4
  } event_kind_e;

  typedef enum logic [3:0] {
    MODE_LINE   = 4'b0001,
    MODE_VALUE  = 4'b0010,
    MODE_QUOTE  = 4'b0100,
    MODE_QCLOSE = 4'b1000
  } parse_mode_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    event_kind_e event_kind;
    logic [31:0] row_index;
    logic [15:0] column_index;
    logic [31:0] byte_offset;
    logic [31:0] value_length;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0]            mask;
    out_item_t [NUM_SLOTS-1:0]       ev;
  } bundle_t;

endpackage

[rtl/csvtok_front.sv]
// Byte classifier: tracks parse state and builds the event bundle for each byte.
module csvtok_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  csvtok_pkg::in_item_t item_i,
  output logic                 push_o,
  output csvtok_pkg::bundle_t  bundle_o
);

  csvtok_pkg::parse_mode_e mode_q, mode_d;
  logic [31:0] row_q, row_d;
  logic [15:0] col_q, col_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] vstart_q, vstart_d;
  logic        prev_cr_q, prev_cr_d;

  logic [7:0]  b;
  logic        is_nl, is_cr, is_quote, is_comma;
  logic [31:0] pos_inc, row_inc, vs_eff, len;
  logic [15:0] col_eff;
  logic        run_value;
  csvtok_pkg::bundle_t bundle;

  assign b        = item_i.data_byte;
  assign is_nl    = (b == csvtok_pkg::CHAR_LF);
  assign is_cr    = (b == csvtok_pkg::CHAR_CR);
  assign is_quote = (b == csvtok_pkg::CHAR_QUOTE);
  assign is_comma = (b == csvtok_pkg::CHAR_COMMA);
  assign pos_inc  = pos_q + 32'd1;
  assign row_inc  = row_q + 32'd1;

  always_comb begin
    mode_d    = mode_q;
    row_d     = row_q;
    col_d     = col_q;
    vstart_d  = vstart_q;
    prev_cr_d = is_cr;
    pos_d     = pos_inc;
    col_eff   = col_q;
    vs_eff    = vstart_q;
    run_value = 1'b0;
    bundle    = '0;

    unique case (mode_q)
      csvtok_pkg::MODE_LINE: begin
        if (is_nl) begin
          bundle.mask[csvtok_pkg::SLOT_BEGIN] = 1'b1;
          bundle.ev[csvtok_pkg::SLOT_BEGIN].event_kind  = csvtok_pkg::EV_ROW_BEGIN;
          bundle.ev[csvtok_pkg::SLOT_BEGIN].row_index   = row_q;
          bundle.ev[csvtok_pkg::SLOT_BEGIN].byte_offset = pos_inc;
          bundle.mask[csvtok_pkg::SLOT_END] = 1'b1;
          bundle.ev[csvtok_pkg::SLOT_END].event_kind  = csvtok_pkg::EV_ROW_END;
          bundle.ev[csvtok_pkg::SLOT_END].row_index   = row_q;
          bundle.ev[csvtok_pkg::SLOT_END].byte_offset = pos_inc;
          row_d = row_inc;
          col_d = '0;
        end else if (!is_cr) begin
          bundle.mask[csvtok_pkg::SLOT_BEGIN] = 1'b1;
          bundle.ev[csvtok_pkg::SLOT_BEGIN].event_kind  = csvtok_pkg::EV_ROW_BEGIN;
          bundle.ev[csvtok_pkg::SLOT_BEGIN].row_index   = row_q;
          bundle.ev[csvtok_pkg::SLOT_BEGIN].byte_offset = pos_q;
          col_d     = '0;
          vstart_d  = pos_q;
          col_eff   = '0;
          vs_eff    = pos_q;
          run_value = 1'b1;
        end
      end
      csvtok_pkg::MODE_VALUE: begin
        run_value = 1'b1;
      end
      csvtok_pkg::MODE_QUOTE: begin
        if (is_quote) begin
          mode_d = csvtok_pkg::MODE_QCLOSE;
        end
      end
      csvtok_pkg::MODE_QCLOSE: begin
        if (is_quote) begin
          mode_d = csvtok_pkg::MODE_QUOTE;
        end else begin
          run_value = 1'b1;
        end
      end
      default: begin
        mode_d = csvtok_pkg::MODE_LINE;
      end
    endcase

    len = pos_q - vs_eff - {31'd0, is_nl & prev_cr_q};

    if (run_value) begin
      priority if (is_nl) begin
        bundle.mask[csvtok_pkg::SLOT_VALUE] = 1'b1;
        bundle.ev[csvtok_pkg::SLOT_VALUE].event_kind   = csvtok_pkg::EV_VALUE;
        bundle.ev[csvtok_pkg::SLOT_VALUE].row_index    = row_q;
        bundle.ev[csvtok_pkg::SLOT_VALUE].column_index = col_eff;
        bundle.ev[csvtok_pkg::SLOT_VALUE].byte_offset  = vs_eff;
        bundle.ev[csvtok_pkg::SLOT_VALUE].value_length = len;
        bundle.mask[csvtok_pkg::SLOT_END] = 1'b1;
        bundle.ev[csvtok_pkg::SLOT_END].event_kind   = csvtok_pkg::EV_ROW_END;
        bundle.ev[csvtok_pkg::SLOT_END].row_index    = row_q;
        bundle.ev[csvtok_pkg::SLOT_END].column_index = col_eff;
        bundle.ev[csvtok_pkg::SLOT_END].byte_offset  = pos_q;
        row_d  = row_inc;
        col_d  = '0;
        mode_d = csvtok_pkg::MODE_LINE;
      end else if (is_quote) begin
        mode_d = csvtok_pkg::MODE_QUOTE;
      end else if (is_comma) begin
        bundle.mask[csvtok_pkg::SLOT_VALUE] = 1'b1;
        bundle.ev[csvtok_pkg::SLOT_VALUE].event_kind   = csvtok_pkg::EV_VALUE;
        bundle.ev[csvtok_pkg::SLOT_VALUE].row_index    = row_q;
        bundle.ev[csvtok_pkg::SLOT_VALUE].column_index = col_eff;
        bundle.ev[csvtok_pkg::SLOT_VALUE].byte_offset  = vs_eff;
        bundle.ev[csvtok_pkg::SLOT_VALUE].value_length = len;
        col_d    = (col_eff == csvtok_pkg::COL_MAX) ? col_eff : col_eff + 16'd1;
        vstart_d = pos_inc;
        mode_d   = csvtok_pkg::MODE_VALUE;
      end else begin
        mode_d = csvtok_pkg::MODE_VALUE;
      end
    end

    if (item_i.final_byte) begin
      bundle.mask[csvtok_pkg::SLOT_FIN] = 1'b1;
      bundle.ev[csvtok_pkg::SLOT_FIN].row_index = row_d;
      if (mode_d == csvtok_pkg::MODE_LINE) begin
        bundle.ev[csvtok_pkg::SLOT_FIN].event_kind  = csvtok_pkg::EV_FINISHED;
        bundle.ev[csvtok_pkg::SLOT_FIN].byte_offset = pos_inc;
      end else begin
        bundle.ev[csvtok_pkg::SLOT_FIN].event_kind   = csvtok_pkg::EV_INCOMPLETE;
        bundle.ev[csvtok_pkg::SLOT_FIN].column_index = col_d;
        bundle.ev[csvtok_pkg::SLOT_FIN].byte_offset  = pos_q;
      end
      mode_d    = csvtok_pkg::MODE_LINE;
      row_d     = '0;
      col_d     = '0;
      pos_d     = '0;
      vstart_d  = '0;
      prev_cr_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= csvtok_pkg::MODE_LINE;
      row_q     <= '0;
      col_q     <= '0;
      pos_q     <= '0;
      vstart_q  <= '0;
      prev_cr_q <= 1'b0;
    end else if (accept_i) begin
      mode_q    <= mode_d;
      row_q     <= row_d;
      col_q     <= col_d;
      pos_q     <= pos_d;
      vstart_q  <= vstart_d;
      prev_cr_q <= prev_cr_d;
    end
  end

  assign push_o   = accept_i && (bundle.mask != '0);
  assign bundle_o = bundle;

endmodule

[rtl/csvtok_queue.sv]
// Small FIFO of event bundles between the classifier and the event sequencer.
module csvtok_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  csvtok_pkg::bundle_t push_data_i,
  input  logic                pop_i,
  output csvtok_pkg::bundle_t head_o,
  output logic                full_o,
  output logic                empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  csvtok_pkg::bundle_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);

endmodule

[rtl/csvtok_back.sv]
// Event sequencer: emits each bundle's events one per cycle unless stalled.
module csvtok_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  csvtok_pkg::bundle_t   head_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output csvtok_pkg::out_item_t out_data_o
);

  csvtok_pkg::bundle_t bundle_q;
  logic [csvtok_pkg::NUM_SLOTS-1:0] rem_q, rem_d, low, rem_left;
  logic out_accept;
  csvtok_pkg::out_item_t sel;

  assign low        = rem_q & (~rem_q + 1'b1);
  assign rem_left   = rem_q & ~low;
  assign out_valid_o = (rem_q != '0);
  assign out_accept = out_valid_o && !out_stall_i;
  assign pop_o      = !empty_i && (!out_valid_o || (out_accept && (rem_left == '0)));

  always_comb begin
    rem_d = rem_q;
    if (out_accept) begin
      rem_d = rem_left;
    end
    if (pop_o) begin
      rem_d = head_i.mask;
    end
  end

  always_comb begin
    priority if (low[csvtok_pkg::SLOT_BEGIN]) begin
      sel = bundle_q.ev[csvtok_pkg::SLOT_BEGIN];
    end else if (low[csvtok_pkg::SLOT_VALUE]) begin
      sel = bundle_q.ev[csvtok_pkg::SLOT_VALUE];
    end else if (low[csvtok_pkg::SLOT_END]) begin
      sel = bundle_q.ev[csvtok_pkg::SLOT_END];
    end else begin
      sel = bundle_q.ev[csvtok_pkg::SLOT_FIN];
    end
    sel.last_of_run = (rem_left == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bundle_q <= head_i;
    end
  end

  assign out_data_o = sel;

endmodule

[rtl/csv_record_tokenizer_core.sv]
// Top level of the CSV record tokenizer: classifier, bundle queue and event sequencer.
//
// Input channel: one buffer byte per transaction (in_valid_i / in_stall_o / in_data_i),
// final_byte set on the last byte of a buffer. Output channel: one parse event per
// transaction (out_valid_o / out_stall_i / out_data_o); last_of_run marks the final
// event caused by a byte.
// A byte may be accepted every cycle while the queue is not full. Each byte that
// causes events becomes one bundle of up to three events in a QueueDepth-entry queue;
// while the receiver does not stall, the sequencer drains one event per cycle, so
// sustained input rate is one byte per cycle while bytes average at most one event,
// and bytes with several events cost one output cycle each. A bundle passes the queue
// memory and the sequencer's bundle register before its first event is presented.
// After the final byte all parse state returns to its reset values and the next byte
// starts a new buffer at offset zero.
// Reset clears the parse state and empties the queue; no event is pending afterward.
// While the receiver stalls, the current event holds; the queue absorbs further bytes
// until it is full, then in_stall_o rises.
module csv_record_tokenizer_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  csvtok_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output csvtok_pkg::out_item_t out_data_o
);

  logic in_accept;
  logic push, pop, q_full, q_empty;
  csvtok_pkg::bundle_t push_bundle, head;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = q_full;

  csvtok_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_data_i),
    .push_o   (push),
    .bundle_o (push_bundle)
  );

  csvtok_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_bundle),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  csvtok_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> ($countones(push_bundle.mask) <= 3))
    else $error("bundle holds more than three events");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.final_byte) |-> push)
    else $error("final byte produced no status event");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last_of_run) |=> out_valid_o)
    else $error("event run ended without last_of_run");

endmodule
